### rtl/core/wfm_pkg.sv
// Shared types, constants and the star-closure function of the wildcard matcher.
package wfm_pkg;

  localparam int MAX_PATTERN_LEN = 32;
  localparam int NUM_PATTERNS    = 4;

  localparam int VEC_LEN      = MAX_PATTERN_LEN + 1;
  localparam int LEN_W        = $clog2(VEC_LEN);
  localparam int CELL_W       = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int CNT_W        = $clog2(NUM_PATTERNS + 1);
  localparam int CLOSE_LEVELS = $clog2(VEC_LEN);

  // Fixed widths of the item fields.
  localparam int OP_W   = 2;
  localparam int IDX_W  = 2;
  localparam int POS_W  = 6;
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 3;
  localparam int HITS_W = 4;

  localparam logic [CHAR_W-1:0] STAR_BYTE = 8'd42;
  localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'd63;

  typedef logic [VEC_LEN-1:0] vec_t;

  localparam vec_t START_VEC = vec_t'(1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_BYTE = 2'd0,
    OP_SET_LEN    = 2'd1,
    OP_SUBJECT    = 2'd2,
    OP_END        = 2'd3
  } op_t;

  typedef struct packed {
    logic              wr_en;
    logic              set_len;
    logic              step;
    logic              restart;
    logic [CELL_W-1:0] slot;
    logic [CHAR_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } lane_cmd_t;

  typedef struct packed {
    logic hit_now;
    logic hit_step;
  } lane_status_t;

  // Parallel prefix closure: a set bit runs forward through every position whose
  // propagate bit is set (prop[i] means a star sits just before position i).
  function automatic vec_t star_close(vec_t v, vec_t prop);
    vec_t g;
    vec_t p;
    vec_t g_n;
    vec_t p_n;
    g = v;
    p = prop;
    for (int lvl = 0; lvl < CLOSE_LEVELS; lvl++) begin
      g_n = g;
      p_n = p;
      for (int i = 0; i < VEC_LEN; i++) begin
        if (i >= (1 << lvl)) begin
          g_n[i] = g[i] | (p[i] & g[i - (1 << lvl)]);
          p_n[i] = p[i] & p[i - (1 << lvl)];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage

### rtl/core/wfm_lane.sv
// One pattern lane: pattern byte cells, length and the NFA active vector.
module wfm_lane
  import wfm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  lane_cmd_t    cmd,
  input  logic [CHAR_W-1:0] subject,
  output lane_status_t status
);

  logic [CHAR_W-1:0] pat [MAX_PATTERN_LEN];
  logic [LEN_W-1:0]  len;
  vec_t              vec;

  logic [MAX_PATTERN_LEN-1:0] star_m;
  logic [MAX_PATTERN_LEN-1:0] take_m;
  vec_t prop;
  vec_t vc;
  vec_t nv;
  vec_t nvc;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      pat[cmd.slot] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      vec <= START_VEC;
    end else begin
      if (cmd.set_len) begin
        len <= cmd.len;
      end
      if (cmd.restart) begin
        vec <= START_VEC;
      end else if (cmd.step) begin
        vec <= nv;
      end
    end
  end

  // Per-cell classification; cells at or past the length take no part.
  always_comb begin
    prop = '0;
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      star_m[i]   = (pat[i] == STAR_BYTE) && (i < int'(len));
      take_m[i]   = (i < int'(len)) && (pat[i] != STAR_BYTE) &&
                    ((pat[i] == ANY_BYTE) || (pat[i] == subject));
      prop[i + 1] = star_m[i];
    end
  end

  always_comb begin
    vc = star_close(vec, prop);
    nv = '0;
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      if (vc[i] && star_m[i]) begin
        nv[i] = 1'b1;
      end
      if (vc[i] && take_m[i]) begin
        nv[i + 1] = 1'b1;
      end
    end
    nvc = star_close(nv, prop);
    status.hit_now  = vc[len];
    status.hit_step = nvc[len];
  end

endmodule

### rtl/core/wildcard_filter_matcher.sv
// Top level of the streaming wildcard pattern matcher.
//
// Items arrive on the s_axis channel. tuser carries the opcode: write a pattern
// byte, set a pattern length, feed one subject byte, or end an empty subject.
// tlast marks the final subject byte. Pattern edits and subject bytes may be
// mixed freely; an edit takes effect at the next subject byte.
// The cfg port sets how many patterns are in use; a count of zero makes every
// subject match. The user must write it only while no item is in flight; the block itself does not enforce this.
// At the end of each subject one result item leaves on m_axis: bit 0 of tdata
// says whether any pattern in use matched, bits 4:1 say which ones did.
// Each accepted item is held in the input register, and all patterns then
// advance in one pass of combinational logic into the result register, so
// m_axis_tvalid rises once the item that ends a subject moves on from the
// input register into the result register.
// One item is taken every cycle while no result is stalled; the pattern lanes update in parallel.
// When the receiver stalls, the result register holds; the input register then
// fills and s_axis_tready drops until the result is taken.
// Reset clears the lengths and the pattern count, returns every active vector
// to its start state and empties both registers; pattern bytes must be written before use.
module wildcard_filter_matcher
  import wfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pattern_index[1:0], position[7:2], char_value[15:8]
  input  logic [OP_W-1:0] s_axis_tuser, // opcode[1:0]
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // matched[0], pattern_hits[4:1], zero[7:5]
  input  logic        cfg_we,
  input  logic [CFG_W-1:0] cfg_data   // pattern_count
);

  // Input register.
  logic              in_valid;
  op_t               in_op;
  logic [IDX_W-1:0]  in_idx;
  logic [POS_W-1:0]  in_pos;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  logic [CNT_W-1:0]  pattern_count;

  logic              advance;
  logic              gives_result;
  logic [LEN_W-1:0]  len_sat;
  logic              any_hit;
  logic [HITS_W-1:0] hits;
  logic              out_matched;
  logic [HITS_W-1:0] out_hits;

  lane_cmd_t    lane_cmd [NUM_PATTERNS];
  lane_status_t lane_st  [NUM_PATTERNS];

  // The item in the input register moves on whenever the result register is
  // free or being emptied in this cycle.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= op_t'(s_axis_tuser);
      in_idx  <= s_axis_tdata[1:0];
      in_pos  <= s_axis_tdata[7:2];
      in_char <= s_axis_tdata[15:8];
      in_last <= s_axis_tlast;
    end
  end

  // The count register saturates at the number of lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count <= '0;
    end else if (cfg_we) begin
      pattern_count <= (int'(cfg_data) > NUM_PATTERNS) ? CNT_W'(NUM_PATTERNS)
                                                       : CNT_W'(cfg_data);
    end
  end

  assign len_sat = (int'(in_pos) > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN)
                                                    : LEN_W'(in_pos);

  always_comb begin
    unique case (in_op)
      OP_WRITE_BYTE: gives_result = 1'b0;
      OP_SET_LEN:    gives_result = 1'b0;
      OP_SUBJECT:    gives_result = in_last;
      OP_END:        gives_result = 1'b1;
      default:       gives_result = 1'b0;
    endcase
  end

  // Commands to the lanes. A write past the last cell or to a missing lane
  // falls on no lane and is dropped.
  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      lane_cmd[p].wr_en   = advance && (in_op == OP_WRITE_BYTE) &&
                            (int'(in_idx) == p) && (int'(in_pos) < MAX_PATTERN_LEN);
      lane_cmd[p].set_len = advance && (in_op == OP_SET_LEN) && (int'(in_idx) == p);
      lane_cmd[p].step    = advance && (in_op == OP_SUBJECT);
      lane_cmd[p].restart = advance && gives_result;
      lane_cmd[p].slot    = CELL_W'(in_pos);
      lane_cmd[p].data    = in_char;
      lane_cmd[p].len     = len_sat;
    end
  end

  for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_lane
    wfm_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .cmd     (lane_cmd[g]),
      .subject (in_char),
      .status  (lane_st[g])
    );
  end

  // An end item reports the vectors as they stand; a last subject byte reports
  // them after that byte has been consumed.
  always_comb begin
    any_hit = (pattern_count == '0);
    hits    = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if ((p < int'(pattern_count)) &&
          ((in_op == OP_END) ? lane_st[p].hit_now : lane_st[p].hit_step)) begin
        any_hit = 1'b1;
        if (p < HITS_W) begin
          hits[p] = 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && gives_result) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && gives_result) begin
      out_matched <= any_hit;
      out_hits    <= hits;
    end
  end

  assign m_axis_tdata = {3'b000, out_hits, out_matched};

`ifndef NO_ASSERTIONS
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && (in_op == OP_END) |=> m_axis_tvalid)
    else $error("end item did not produce a result");

  a_hits_imply_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[4:1] != '0) |-> m_axis_tdata[0])
    else $error("pattern hit reported without match");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending result");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(pattern_count) <= NUM_PATTERNS)
    else $error("pattern count above lane count");
`endif

endmodule

### dv/wildcard_filter_matcher_tb.sv
// Self-checking testbench for the streaming wildcard pattern matcher.
module wildcard_filter_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfm_pkg::*;

  // One input item as the sender sees it, and one result item as predicted.
  typedef logic [CHAR_W-1:0] byte_q_t [$];

  typedef struct {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] chr;
    logic              last;
  } match_item_t;

  typedef struct {
    logic              matched;
    logic [HITS_W-1:0] hits;
  } verdict_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;  // pattern_index[1:0], position[7:2], char_value[15:8]
  logic [OP_W-1:0]   s_axis_tuser  = '0;  // opcode[1:0]
  logic              s_axis_tlast  = 1'b0; // last_char
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // matched[0], pattern_hits[4:1], zero[7:5]
  logic              cfg_we        = 1'b0;
  logic [CFG_W-1:0]  cfg_data      = '0;  // pattern_count

  wildcard_filter_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Safety net: the slowest legal run is far below this.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between the stimulus, the driver and the monitor.
  // ---------------------------------------------------------------------------
  match_item_t pending_items [$];      // items waiting to be offered to the block
  verdict_t    expected_verdicts [$];  // predicted results, oldest first
  int          error_count  = 0;
  int          results_seen = 0;
  int          gap_pct      = 30;      // chance in percent that a side idles

  // Our own copy of the matcher: pattern store, lengths, NFA vectors, count.
  logic [CHAR_W-1:0] pat_mem [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [LEN_W-1:0]  pat_len [NUM_PATTERNS];
  vec_t              nfa     [NUM_PATTERNS];
  int                active_count;

  // Which pattern bytes the stimulus has written so far. A length is only
  // ever set so that every byte below it has been written.
  logic [MAX_PATTERN_LEN-1:0] loaded [NUM_PATTERNS];
  int                         fed = 0;  // subject bytes and subject ends issued

  // Gap lengths: none with a chance set by gap_pct, mostly short when there is one, now and then long.
  function automatic int pick_gap();
    if (int'($urandom_range(99)) >= gap_pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A set bit at a star position also enables the position after it. The scan
  // goes upward so that a run of stars passes the bit all the way through.
  function automatic vec_t close_stars(int p, vec_t v);
    for (int i = 0; i < MAX_PATTERN_LEN; i++)
      if (i < pat_len[p] && v[i] && pat_mem[p][i] == STAR_BYTE) v[i+1] = 1'b1;
    return v;
  endfunction

  // Applies one accepted item to the matcher copy and queues the result that
  // it causes, if any.
  task automatic advance_matcher(match_item_t it);
    vec_t     v;
    vec_t     nv;
    verdict_t vd;
    bit       report;
    report = 1'b0;
    case (it.op)
      OP_WRITE_BYTE: begin
        // Writes past the end of the store fall away.
        if (it.pos < MAX_PATTERN_LEN) pat_mem[it.idx][it.pos] = it.chr;
      end
      OP_SET_LEN: begin
        pat_len[it.idx] = (it.pos > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN) : it.pos;
      end
      OP_SUBJECT: begin
        for (int p = 0; p < NUM_PATTERNS; p++) begin
          v  = close_stars(p, nfa[p]);
          nv = '0;
          for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (i < pat_len[p] && v[i]) begin
              if (pat_mem[p][i] == STAR_BYTE) nv[i] = 1'b1;
              else if (pat_mem[p][i] == ANY_BYTE || pat_mem[p][i] == it.chr) nv[i+1] = 1'b1;
            end
          end
          nfa[p] = nv;
        end
        report = it.last;
      end
      default: report = 1'b1;  // an end mark closes the string where it stands
    endcase
    if (report) begin
      vd.matched = (active_count == 0);
      vd.hits    = '0;
      for (int p = 0; p < active_count; p++) begin
        v = close_stars(p, nfa[p]);
        if (v[pat_len[p]]) begin
          vd.matched = 1'b1;
          vd.hits[p] = 1'b1;
        end
      end
      expected_verdicts.push_back(vd);
      for (int p = 0; p < NUM_PATTERNS; p++) nfa[p] = START_VEC;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the pending items one at a time, with random gaps between
  // them. Every accepted item goes through the matcher copy at its handshake.
  // ---------------------------------------------------------------------------
  match_item_t offered;
  int          send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) advance_matcher(offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered.chr, offered.pos, offered.idx};
          s_axis_tuser  <= offered.op;
          s_axis_tlast  <= offered.last;
          send_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long back-pressure: once, after a few dozen results and while the sender
  // still has plenty to offer, the receiver holds off so that the block backs
  // up and drops s_axis_tready.
  // ---------------------------------------------------------------------------
  int hold_left      = 0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (long_hold_left > 0) begin
        long_hold_left--;
      end else if (!long_hold_done && results_seen >= 40 && pending_items.size() > 8) begin
        long_hold_done = 1'b1;
        long_hold_left = 200;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each result with the oldest prediction and stalls the
  // block at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    int       gap;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("result item with nothing expected: tdata=%h", m_axis_tdata);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (m_axis_tdata[0] !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, m_axis_tdata[0]);
            error_count++;
          end
          if (m_axis_tdata[4:1] !== want.hits) begin
            $error("pattern_hits: expected %b, got %b", want.hits, m_axis_tdata[4:1]);
            error_count++;
          end
          if (m_axis_tdata[7:5] !== 3'b000) begin
            $error("tdata padding: expected 000, got %b", m_axis_tdata[7:5]);
            error_count++;
          end
        end
      end
      if (long_hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          hold_left = gap - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic put(op_t op, int idx, int pos, int chr, bit last);
    match_item_t it;
    it.op   = op;
    it.idx  = IDX_W'(idx);
    it.pos  = POS_W'(pos);
    it.chr  = CHAR_W'(chr);
    it.last = last;
    pending_items.push_back(it);
    if (op == OP_SUBJECT || op == OP_END) fed++;
  endtask

  // The end mark means nothing on edits, so it is set at random there.
  function automatic bit stray_mark();
    return $urandom_range(3) == 0;
  endfunction

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic int loaded_prefix(int p);
    int n;
    n = 0;
    while (n < MAX_PATTERN_LEN && loaded[p][n]) n++;
    return n;
  endfunction

  // Random text over a small alphabet so that matches are frequent; patterns
  // get stars and question marks, and both get the odd arbitrary byte.
  task automatic pick_text(ref byte_q_t q, input int n, input bit for_pattern);
    int r;
    q.delete();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (for_pattern && r < 20) q.push_back(STAR_BYTE);
      else if (for_pattern && r < 40) q.push_back(ANY_BYTE);
      else if (r < 92) q.push_back(CHAR_W'("a") + CHAR_W'($urandom_range(2)));
      else q.push_back(CHAR_W'($urandom_range(255)));
    end
  endtask

  task automatic load_pattern(int p, byte_q_t q);
    for (int i = 0; i < q.size(); i++) begin
      put(OP_WRITE_BYTE, p, i, q[i], stray_mark());
      loaded[p][i] = 1'b1;
    end
    put(OP_SET_LEN, p, q.size(), $urandom_range(255), stray_mark());
  endtask

  // A single edit: a byte written anywhere, past the store now and then, or a
  // new length that stays within the bytes written so far.
  task automatic random_edit();
    int p;
    int pos;
    int pf;
    p = $urandom_range(NUM_PATTERNS - 1);
    if ($urandom_range(1) == 0) begin
      pos = ($urandom_range(99) < 15) ? $urandom_range(MAX_PATTERN_LEN, 63)
                                      : $urandom_range(MAX_PATTERN_LEN - 1);
      put(OP_WRITE_BYTE, p, pos,
          ($urandom_range(1) == 0) ? STAR_BYTE : CHAR_W'("a") + $urandom_range(2),
          stray_mark());
      if (pos < MAX_PATTERN_LEN) loaded[p][pos] = 1'b1;
    end else begin
      pf = loaded_prefix(p);
      put(OP_SET_LEN, p, (pf == MAX_PATTERN_LEN) ? $urandom_range(63) : $urandom_range(pf),
          $urandom_range(255), stray_mark());
    end
  endtask

  // Sends one subject string. An empty one is a bare end mark. With cut set,
  // the string ends through an end mark instead of tlast on its final byte.
  task automatic send_subject(byte_q_t q, bit cut, int edit_pct);
    if (q.size() == 0) begin
      put(OP_END, $urandom_range(3), $urandom_range(63), $urandom_range(255), stray_mark());
      return;
    end
    for (int i = 0; i < q.size(); i++) begin
      if (i > 0 && int'($urandom_range(99)) < edit_pct) random_edit();
      put(OP_SUBJECT, $urandom_range(3), $urandom_range(63), q[i],
          !cut && i == q.size() - 1);
    end
    if (cut) put(OP_END, $urandom_range(3), $urandom_range(63), $urandom_range(255),
                 stray_mark());
  endtask

  // Waits until the block has nothing left to do, with a margin for the
  // two-stage pipeline behind items that cause no result.
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_count(int c);
    drain();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(c);
    @(posedge clk);
    cfg_we   <= 1'b0;
    active_count = (c > NUM_PATTERNS) ? NUM_PATTERNS : c;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, a directed part, then random phases, each under its
  // own pattern count and idling rate.
  // ---------------------------------------------------------------------------
  initial begin
    int      counts [8];
    int      phase_start;
    int      r;
    byte_q_t q;
    counts = '{0, 7, 1, 2, 3, 5, 6, 4};
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      pat_len[p] = '0;
      nfa[p]     = START_VEC;
      loaded[p]  = '0;
    end
    active_count = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: star, a trailing question mark, a bare star, an empty
    // pattern, an empty subject, case sensitivity, a string closed by an end mark
    // and an edit that lands in the middle of a string.
    set_count(NUM_PATTERNS);
    load_pattern(0, to_bytes("a*b"));
    load_pattern(1, to_bytes("a?"));
    load_pattern(2, to_bytes("*"));
    put(OP_SET_LEN, 3, 0, 8'hff, 1'b1);
    send_subject(to_bytes(""), 1'b0, 0);
    send_subject(to_bytes("ab"), 1'b0, 0);
    send_subject(to_bytes("a"), 1'b0, 0);
    send_subject(to_bytes("aXb"), 1'b0, 0);
    send_subject(to_bytes("Ab"), 1'b0, 0);
    send_subject(to_bytes("ab"), 1'b1, 0);
    put(OP_SUBJECT, 0, 0, "a", 1'b0);
    put(OP_WRITE_BYTE, 0, 2, ANY_BYTE, 1'b0);
    put(OP_SUBJECT, 3, 63, "c", 1'b0);
    put(OP_SUBJECT, 0, 0, 8'hff, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      set_count(counts[ph]);
      gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 20 : 60;
      if (ph == 1) begin
        // One full-length pattern with an oversized length that saturates.
        pick_text(q, MAX_PATTERN_LEN, 1'b1);
        for (int i = 0; i < MAX_PATTERN_LEN; i++)
          if ($urandom_range(9) != 0) q[i] = ANY_BYTE;
        load_pattern(3, q);
        put(OP_SET_LEN, 3, $urandom_range(MAX_PATTERN_LEN + 1, 63), 0, 1'b0);
      end
      phase_start = fed;
      while (fed - phase_start < 170) begin
        r = $urandom_range(99);
        if (r < 6) begin
          pick_text(q, ($urandom_range(99) < 90) ? $urandom_range(6)
                                                 : $urandom_range(7, MAX_PATTERN_LEN), 1'b1);
          load_pattern($urandom_range(NUM_PATTERNS - 1), q);
        end else if (r < 10) begin
          random_edit();
        end else begin
          pick_text(q, ($urandom_range(99) < 85) ? $urandom_range(7) : $urandom_range(8, 40),
                    1'b0);
          send_subject(q, r < 16, (r < 20) ? 15 : 0);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
